FILE: hdl/bdus_pkg.sv
// shared types, constants and helpers for the bcd date to epoch seconds converter
package bdus_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int DAYS_W = 32;
  localparam int TOD_W  = 20;

  localparam logic [31:0] SECONDS_PER_DAY  = 32'd86400;
  localparam logic [19:0] SECONDS_PER_HOUR = 20'd3600;
  localparam logic [19:0] SECONDS_PER_MIN  = 20'd60;

  localparam logic [8:0]  YEAR_BIAS      = 9'd30;   // 2000 - 1970
  localparam logic [16:0] DAYS_PER_YEAR  = 17'd365;
  localparam logic [5:0]  LEAPS_BEFORE   = 6'd7;    // leap years 1970 to 1999
  localparam logic [7:0]  CENTURY_YEAR   = 8'd100;  // 2100, not a leap year
  localparam logic [7:0]  FIRST_NO_LEAP  = 8'd101;  // first year that counts 2100
  localparam logic [7:0]  FEBRUARY       = 8'd2;
  localparam logic [7:0]  DECEMBER       = 8'd12;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // work item handed from front to back
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } bdus_item_t;

  // two bcd digits to binary, digits above nine taken at face value
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

endpackage

FILE: hdl/bdus_ifs.sv
// handshake channels for date words in and epoch words out
interface bdus_date_if;
  logic       valid;
  logic       ready;
  logic [7:0] second_bcd;
  logic [7:0] minute_bcd;
  logic [7:0] hour_bcd;
  logic [7:0] day_bcd;
  logic [7:0] month_bcd;
  logic [7:0] year_bcd;

  modport source (output valid, second_bcd, minute_bcd, hour_bcd, day_bcd, month_bcd,
                  year_bcd, input ready);
  modport sink (input valid, second_bcd, minute_bcd, hour_bcd, day_bcd, month_bcd,
                year_bcd, output ready);
endinterface

interface bdus_epoch_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink (input valid, epoch_seconds, output ready);
endinterface

FILE: hdl/bdus_front.sv
// front end: decodes the bcd bytes into a day count and a time of day
module bdus_front (
  bdus_date_if.sink          date,
  input  logic               full,
  output logic               push,
  output bdus_pkg::bdus_item_t item
);
  import bdus_pkg::*;

  logic [7:0]  sec, min, hour, day, month, yd;
  logic [8:0]  years;
  logic [16:0] year_days;
  logic [8:0]  yd_round;
  logic [5:0]  leaps;
  logic [8:0]  month_off;
  logic        leap_day;

  always_comb begin
    sec   = bcd_decode(date.second_bcd);
    min   = bcd_decode(date.minute_bcd);
    hour  = bcd_decode(date.hour_bcd);
    day   = bcd_decode(date.day_bcd);
    month = bcd_decode(date.month_bcd);
    yd    = bcd_decode(date.year_bcd);

    years     = {1'b0, yd} + YEAR_BIAS;
    year_days = {8'd0, years} * DAYS_PER_YEAR;

    // leap years from 2000 up to the year before, 2100 dropped
    yd_round = {1'b0, yd} + 9'd3;
    leaps    = LEAPS_BEFORE + yd_round[7:2] - {5'd0, (yd >= FIRST_NO_LEAP)};

    month_off = '0;
    if ((month != 8'd0) && (month <= DECEMBER)) begin
      month_off = MONTH_START[month[3:0] - 4'd1];
    end

    leap_day = (month > FEBRUARY) && (yd[1:0] == 2'b00) && (yd != CENTURY_YEAR);

    item.days = DAYS_W'(year_days) + DAYS_W'(leaps) + DAYS_W'(month_off)
              + DAYS_W'(leap_day) + DAYS_W'(day) - DAYS_W'(1);
    item.tod  = TOD_W'(hour) * SECONDS_PER_HOUR + TOD_W'(min) * SECONDS_PER_MIN
              + TOD_W'(sec);
  end

  assign date.ready = !full;
  assign push       = date.valid && !full;

endmodule

FILE: hdl/bdus_queue.sv
// short fifo between front and back
module bdus_queue #(
  parameter int DEPTH = bdus_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bdus_pkg::bdus_item_t wr_item,
  output logic                 full,
  input  logic                 pop,
  output bdus_pkg::bdus_item_t rd_item,
  output logic                 avail
);
  import bdus_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bdus_item_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count, count_next;

  assign full    = (count == CNT_W'(DEPTH));
  assign avail   = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + CNT_W'(1);
    if (pop && !push) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
  end

endmodule

FILE: hdl/bdus_back.sv
// back end: scales the day count to seconds and holds the output word
module bdus_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 avail,
  input  bdus_pkg::bdus_item_t head,
  output logic                 pop,
  bdus_epoch_if.source         epoch
);
  import bdus_pkg::*;

  logic [31:0] total;

  assign total = head.days * SECONDS_PER_DAY + 32'(head.tod);
  assign pop   = avail && (!epoch.valid || epoch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch.valid <= 1'b0;
    end else if (!epoch.valid || epoch.ready) begin
      epoch.valid <= avail;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) epoch.epoch_seconds <= total;
  end

endmodule

FILE: hdl/bcd_date_to_unix_seconds.sv
// top level: rtc bcd date and time words in, unix epoch seconds words out
//
// Each date word (second, minute, hour, day, month and two-digit year, all in
// bcd) yields one 32-bit count of seconds since 1970-01-01 00:00:00, wrapping
// modulo 2^32. Years run from 2000 to 2165 with gregorian leap rules; bcd
// digits above nine are used at face value, a month outside one to twelve adds
// no month offset, and day zero stands for the last day of the month before.
// The front end decodes a word and forms its day count and time of day in the
// cycle it is accepted and writes them to a short fifo; the back end takes the
// head of the fifo, multiplies the day count by 86400 and registers the result.
// One word is accepted every cycle while the fifo is not full, and a result
// passes through a fifo slot and then the output register. The fifo lets input
// keep flowing for QUEUE_DEPTH more words while the output register waits.
module bcd_date_to_unix_seconds #(
  parameter int QUEUE_DEPTH = bdus_pkg::QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  bdus_date_if.sink    date,
  bdus_epoch_if.source epoch
);
  import bdus_pkg::*;

  // front to fifo
  bdus_item_t wr_item;
  logic       push;
  logic       q_full;

  // fifo to back
  bdus_item_t rd_item;
  logic       pop;
  logic       q_avail;

  bdus_front u_front (
    .date (date),
    .full (q_full),
    .push (push),
    .item (wr_item)
  );

  bdus_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (pop),
    .rd_item (rd_item),
    .avail   (q_avail)
  );

  bdus_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (q_avail),
    .head  (rd_item),
    .pop   (pop),
    .epoch (epoch)
  );

`ifndef SYNTH
  // input only stalls when the fifo is full
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !date.ready |-> q_full)
    else $error("date word stalled with fifo space free");

  // a word taken from the fifo shows at the output next cycle
  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> epoch.valid)
    else $error("popped word did not reach the output");

  // never pop an empty fifo
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_avail)
    else $error("pop from empty fifo");
`endif

endmodule
